### hdl/assert_macros.svh
// assertion macros used by the top level's self checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define ASSERT_ALWAYS(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// property must never hold at a clock edge out of reset
`define ASSERT_NEVER(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) !(prop)) else $error(msg);

`endif

### hdl/lsbs_pkg.sv
// shared types and constants for the lsb audio stego block
`timescale 1ns / 1ps

package lsbs_pkg;

	// field widths
	localparam int BYTE_W = 8;
	localparam int STRIDE_W = 6;
	localparam int OFFSET_W = 5;

	// stride limits and default
	localparam logic [STRIDE_W-1:0] STRIDE_MIN = 6'd8;
	localparam logic [STRIDE_W-1:0] STRIDE_MAX = 6'd32;
	localparam logic [STRIDE_W-1:0] STRIDE_RESET = 6'd16;

	// header settings
	localparam int LENGTH_BYTES_DEFAULT = 4;
	localparam int LENGTH_WORD_BYTES = 4;
	localparam int LENGTH_W = 32;

	// queue between front and back
	localparam int QUEUE_DEPTH = 2;

	// configuration port
	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W = STRIDE_W;
	localparam logic [CFG_INDEX_W-1:0] CFG_EMBED_MODE = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_GROUP_STRIDE = 1'd1;

	// carrier slot numbers within a group
	localparam logic [1:0] SLOT_0 = 2'd0;
	localparam logic [1:0] SLOT_1 = 2'd1;
	localparam logic [1:0] SLOT_2 = 2'd2;
	localparam logic [1:0] SLOT_3 = 2'd3;

	// classified item handed from front to back
	typedef struct packed {
		logic [BYTE_W-1:0] out_byte;
		logic taken;
		logic [1:0] pair;
		logic start;
		logic gather;
		logic last;
	} lsbs_item_t;

	// queue status seen by the top level and the back
	typedef struct packed {
		logic empty;
		logic full;
	} q_status_t;

endpackage

### hdl/lsbs_in_if.sv
// input channel: one carrier byte transaction with its message side fields
`timescale 1ns / 1ps

interface lsbs_in_if;
	logic valid;
	logic ready;
	logic [7:0] carrier_byte;
	logic [7:0] message_byte;
	logic message_available;
	logic data_start;

	modport source (
		output valid, carrier_byte, message_byte, message_available, data_start,
		input ready
	);
	modport sink (
		input valid, carrier_byte, message_byte, message_available, data_start,
		output ready
	);
endinterface

### hdl/lsbs_out_if.sv
// output channel: one result transaction per carrier byte
`timescale 1ns / 1ps

interface lsbs_out_if;
	logic valid;
	logic ready;
	logic [7:0] out_byte;
	logic message_taken;
	logic [7:0] recovered_byte;
	logic recovered_valid;
	logic extract_done;

	modport source (
		output valid, out_byte, message_taken, recovered_byte, recovered_valid,
			extract_done,
		input ready
	);
	modport sink (
		input valid, out_byte, message_taken, recovered_byte, recovered_valid,
			extract_done,
		output ready
	);
endinterface

### hdl/lsbs_queue.sv
// short fifo of classified items between front and back
`timescale 1ns / 1ps

module lsbs_queue
	import lsbs_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  lsbs_item_t push_item,
	input  logic pop,
	output lsbs_item_t pop_item,
	output q_status_t status
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

	lsbs_item_t entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	// status flags
	assign status.empty = (count_q == '0);
	assign status.full = (count_q == CNT_W'(QUEUE_DEPTH));
	assign pop_item = entry_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### hdl/lsbs_front.sv
// front end: group position tracking, slot classification and embedding
`timescale 1ns / 1ps

module lsbs_front
	import lsbs_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic embed_mode,
	input  logic [STRIDE_W-1:0] group_stride,
	input  logic accept,
	input  logic [BYTE_W-1:0] carrier_byte,
	input  logic [BYTE_W-1:0] message_byte,
	input  logic message_available,
	input  logic data_start,
	output lsbs_item_t item
);

	logic [OFFSET_W-1:0] offset_q;
	logic [BYTE_W-1:0] latch_q;
	logic active_q;

	logic [STRIDE_W-1:0] stride;
	logic [3:0] step;
	logic [OFFSET_W-1:0] step1, step2, step3;
	logic [OFFSET_W-1:0] offset;
	logic [STRIDE_W-1:0] offset_inc;
	logic [OFFSET_W-1:0] offset_next;
	logic hit0, hit1, hit2, hit3, slot_valid;
	logic [1:0] slot;
	logic [BYTE_W-1:0] latch_next;
	logic active_next;
	logic taken;
	logic [1:0] pair;

	// clamp stride and derive slot spacing
	always_comb begin
		if (group_stride < STRIDE_MIN) begin
			stride = STRIDE_MIN;
		end else if (group_stride > STRIDE_MAX) begin
			stride = STRIDE_MAX;
		end else begin
			stride = group_stride;
		end
		step = stride[5:2];
		step1 = {1'b0, step};
		step2 = {step, 1'b0};
		step3 = step1 + step2;
	end

	// slot classification and next position
	always_comb begin
		offset = data_start ? '0 : offset_q;
		hit0 = (offset == '0);
		hit1 = (offset == step1);
		hit2 = (offset == step2);
		hit3 = (offset == step3);
		slot_valid = hit0 | hit1 | hit2 | hit3;
		if (hit3) begin
			slot = SLOT_3;
		end else if (hit2) begin
			slot = SLOT_2;
		end else if (hit1) begin
			slot = SLOT_1;
		end else begin
			slot = SLOT_0;
		end
		offset_inc = {1'b0, offset} + 6'd1;
		offset_next = (offset_inc >= stride) ? '0 : offset_inc[OFFSET_W-1:0];
	end

	// message latch and bit pair substitution
	always_comb begin
		latch_next = data_start ? '0 : latch_q;
		active_next = data_start ? 1'b0 : active_q;
		taken = 1'b0;
		if (embed_mode && hit0) begin
			if (message_available) begin
				latch_next = message_byte;
				active_next = 1'b1;
				taken = 1'b1;
			end else begin
				active_next = 1'b0;
			end
		end
		case (slot)
			SLOT_0: pair = latch_next[7:6];
			SLOT_1: pair = latch_next[5:4];
			SLOT_2: pair = latch_next[3:2];
			SLOT_3: pair = latch_next[1:0];
			default: pair = latch_next[1:0];
		endcase
		item.out_byte = carrier_byte;
		if (embed_mode && active_next && slot_valid) begin
			item.out_byte = {carrier_byte[7:2], pair};
		end
		item.taken = taken;
		item.pair = carrier_byte[1:0];
		item.start = data_start;
		item.gather = !embed_mode && slot_valid;
		item.last = hit3;
	end

	// front state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= '0;
			latch_q <= '0;
			active_q <= 1'b0;
		end else if (accept) begin
			offset_q <= offset_next;
			latch_q <= latch_next;
			active_q <= active_next;
		end
	end

endmodule

### hdl/lsbs_back.sv
// back end: pair gathering, header decode, payload emission and output register
`timescale 1ns / 1ps

module lsbs_back
	import lsbs_pkg::*;
#(
	parameter int LENGTH_BYTES = LENGTH_BYTES_DEFAULT
) (
	input  logic clk,
	input  logic arst_n,
	input  lsbs_item_t item,
	input  q_status_t q_status,
	output logic pop,
	lsbs_out_if.source tx
);

	localparam int HC_W = $clog2(LENGTH_BYTES + 1);
	localparam logic [HC_W-1:0] HC_LIMIT = HC_W'(LENGTH_BYTES);

	logic [BYTE_W-1:0] gather_q;
	logic [HC_W-1:0] header_q;
	logic [LENGTH_W-1:0] length_q;
	logic [LENGTH_W-1:0] count_q;

	logic tx_valid_q;
	logic [BYTE_W-1:0] out_byte_q;
	logic taken_q;
	logic [BYTE_W-1:0] rec_byte_q;
	logic rec_valid_q;
	logic done_q;

	logic [BYTE_W-1:0] gather_n;
	logic [HC_W-1:0] header_n;
	logic [LENGTH_W-1:0] length_n;
	logic [LENGTH_W-1:0] count_n;
	logic [BYTE_W-1:0] rec_byte;
	logic rec_valid;
	logic done;
	logic load;

	// header complete and every announced payload byte sent
	function automatic logic finished(input logic [HC_W-1:0] hc,
			input logic [LENGTH_W-1:0] len, input logic [LENGTH_W-1:0] cnt);
		logic [LENGTH_W:0] sum;
		sum = {1'b0, cnt} + (LENGTH_W + 1)'(LENGTH_BYTES);
		return (hc >= HC_LIMIT) && (sum >= {1'b0, len});
	endfunction

	// output register frees when empty or taken
	assign load = !tx_valid_q || tx.ready;
	assign pop = load && !q_status.empty;

	// gather and decode for the item at the queue head
	always_comb begin
		gather_n = item.start ? '0 : gather_q;
		header_n = item.start ? '0 : header_q;
		length_n = item.start ? '0 : length_q;
		count_n = item.start ? '0 : count_q;
		rec_byte = '0;
		rec_valid = 1'b0;
		if (item.gather) begin
			gather_n = {gather_n[5:0], item.pair};
			if (item.last) begin
				if (header_n < HC_LIMIT) begin
					if (int'(header_n) < LENGTH_WORD_BYTES) begin
						length_n = length_n | (LENGTH_W'(gather_n) << {header_n, 3'b000});
					end
					header_n = header_n + 1'b1;
				end else if (!finished(header_n, length_n, count_n)) begin
					rec_byte = gather_n;
					rec_valid = 1'b1;
					count_n = count_n + 1'b1;
				end
			end
		end
		done = finished(header_n, length_n, count_n);
	end

	// extraction state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gather_q <= '0;
			header_q <= '0;
			length_q <= '0;
			count_q <= '0;
		end else if (pop) begin
			gather_q <= gather_n;
			header_q <= header_n;
			length_q <= length_n;
			count_q <= count_n;
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_valid_q <= 1'b0;
		end else if (load) begin
			tx_valid_q <= !q_status.empty;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (pop) begin
			out_byte_q <= item.out_byte;
			taken_q <= item.taken;
			rec_byte_q <= rec_byte;
			rec_valid_q <= rec_valid;
			done_q <= done;
		end
	end

	assign tx.valid = tx_valid_q;
	assign tx.out_byte = out_byte_q;
	assign tx.message_taken = taken_q;
	assign tx.recovered_byte = rec_byte_q;
	assign tx.recovered_valid = rec_valid_q;
	assign tx.extract_done = done_q;

endmodule

### hdl/lsb_audio_stego.sv
// lsb audio stego top level: two-bit lsb embed and extract on a byte stream
//
// usage: carrier bytes enter on rx, one per transaction, with the next message
// byte, its availability flag and a data_start mark on the first data byte.
// every rx transaction yields exactly one tx transaction in order: the carrier
// byte after embedding, a message_taken flag, an extracted payload byte with
// its valid flag, and extract_done once the announced payload has been sent.
// embed_mode and group_stride must be written on the cfg port only while the
// stream is idle; the block itself does not enforce this. the front tracks
// the group position and embeds; a two entry fifo then feeds the back, which
// gathers pairs and decodes the length header. throughput is one transaction
// per cycle while tx does not stall, set by the single output register and
// the back end state update. reset clears all counters, the fifo and the
// output valid, selects extract mode and a stride of 16. when tx stalls the
// result holds in the output register, the fifo absorbs up to two more
// transactions, and rx ready drops only when the fifo is full.
`timescale 1ns / 1ps

module lsb_audio_stego
	import lsbs_pkg::*;
#(
	parameter int LENGTH_BYTES = LENGTH_BYTES_DEFAULT
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	lsbs_in_if.sink rx,
	lsbs_out_if.source tx
);

	`include "assert_macros.svh"

	logic embed_mode_q;
	logic [STRIDE_W-1:0] group_stride_q;
	logic push;
	logic pop;
	lsbs_item_t front_item;
	lsbs_item_t head_item;
	q_status_t q_stat;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			embed_mode_q <= 1'b0;
			group_stride_q <= STRIDE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_EMBED_MODE: embed_mode_q <= cfg_data[0];
				CFG_GROUP_STRIDE: group_stride_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// input transaction accepted while the fifo has room
	assign rx.ready = !q_stat.full;
	assign push = rx.valid && rx.ready;

	lsbs_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.embed_mode(embed_mode_q),
		.group_stride(group_stride_q),
		.accept(push),
		.carrier_byte(rx.carrier_byte),
		.message_byte(rx.message_byte),
		.message_available(rx.message_available),
		.data_start(rx.data_start),
		.item(front_item)
	);

	lsbs_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_item(front_item),
		.pop(pop),
		.pop_item(head_item),
		.status(q_stat)
	);

	lsbs_back #(
		.LENGTH_BYTES(LENGTH_BYTES)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.item(head_item),
		.q_status(q_stat),
		.pop(pop),
		.tx(tx)
	);

	// checks
	`ASSERT_NEVER(a_no_overflow, push && q_stat.full, "push into full fifo")
	`ASSERT_NEVER(a_no_underflow, pop && q_stat.empty, "pop from empty fifo")
	`ASSERT_NEVER(a_mode_exclusive, tx.valid && tx.recovered_valid && tx.message_taken,
		"message taken and byte recovered in one transaction")
	`ASSERT_ALWAYS(a_pop_when_free, (!tx.valid && !q_stat.empty) |-> pop,
		"back end idles with work queued")

endmodule
